// ===== rtl/core/tlpd_pkg.sv =====
// Shared types and constants of the typed length-prefixed deframer.
package tlpd_pkg;

    // Widths of the item fields
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned LEN_W  = 32;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CTRL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    // Special type bytes
    localparam logic [BYTE_W-1:0] TYPE_CTRL_MAX = 8'h02;
    localparam logic [BYTE_W-1:0] TYPE_FILLER   = 8'hFF;

    // Phase codes of the parser
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] packet_type;
        logic [BYTE_W-1:0] data_byte;
        logic              last_of_packet;
        logic [LEN_W-1:0]  payload_length;
    } result_t;

endpackage

// ===== rtl/core/typed_length_prefixed_deframer.sv =====
// Top level of the typed length-prefixed deframer.
//
// Input channel (s_*): one received link byte per item. Output channel (m_*):
// one result per control packet, per payload byte and per empty data packet.
// In idle a byte of 0xFF is dropped; types 0x00..0x02 are one-byte control
// packets; any other type is followed by LENGTH_BYTES big-endian length bytes
// (low 32 bits kept) and that many payload bytes. Header bytes give no result unless the length is zero.
//
// Output: each result is on m_* the cycle after its byte is accepted.
// Throughput: one byte per cycle; the parser state and the output register
// are updated in the same cycle, so s_tready stays high while the output
// register is empty or being taken.
// Stall: while a result waits with m_tready low, s_tready is low and the
// result holds. Bytes that give no result still wait for that slot to clear.
// Reset: aresetn (synchronous, active low) returns the parser to idle and
// empties the output register.
module typed_length_prefixed_deframer #(
    parameter int unsigned LENGTH_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] data_byte, [39:8] payload_length
    output logic [9:0]  m_tuser,   // [1:0] kind, [9:2] packet_type
    output logic        m_tlast    // last_of_packet
);

    localparam int unsigned CNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LENGTH_BYTES - 1);

    // Parser state
    logic [1:0]                         phase_reg, phase_next;
    logic [tlpd_pkg::BYTE_W-1:0]        held_type_reg, held_type_next;
    logic [CNT_W-1:0]                   seen_reg, seen_next;
    logic [tlpd_pkg::LEN_W-1:0]         length_shift_reg, length_shift_next;
    logic [tlpd_pkg::LEN_W-1:0]         remaining_reg, remaining_next;

    // Output register
    logic                               out_valid_reg, out_valid_next;
    tlpd_pkg::result_t                  out_reg;

    logic                               accept;
    logic                               res_valid;
    tlpd_pkg::result_t                  res;
    logic [tlpd_pkg::LEN_W-1:0]         shifted;
    logic                               is_last;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign shifted  = {length_shift_reg[tlpd_pkg::LEN_W-tlpd_pkg::BYTE_W-1:0], s_tdata};
    assign is_last  = (remaining_reg <= tlpd_pkg::LEN_W'(1));

    // Parse one byte
    always_comb begin
        phase_next        = phase_reg;
        held_type_next    = held_type_reg;
        seen_next         = seen_reg;
        length_shift_next = length_shift_reg;
        remaining_next    = remaining_reg;
        res_valid         = 1'b0;
        res               = '0;
        if (accept) begin
            unique case (phase_reg)
                tlpd_pkg::PH_LEN: begin
                    length_shift_next = shifted;
                    seen_next         = seen_reg + CNT_W'(1);
                    if (seen_reg == CNT_LAST) begin
                        seen_next = '0;
                        if (shifted == '0) begin
                            phase_next           = tlpd_pkg::PH_IDLE;
                            res_valid            = 1'b1;
                            res.kind             = tlpd_pkg::KIND_EMPTY;
                            res.packet_type      = held_type_reg;
                            res.last_of_packet   = 1'b1;
                        end else begin
                            remaining_next = shifted;
                            phase_next     = tlpd_pkg::PH_DATA;
                        end
                    end
                end
                tlpd_pkg::PH_DATA: begin
                    res_valid          = 1'b1;
                    res.kind           = tlpd_pkg::KIND_DATA;
                    res.packet_type    = held_type_reg;
                    res.data_byte      = s_tdata;
                    res.last_of_packet = is_last;
                    res.payload_length = length_shift_reg;
                    remaining_next     = is_last ? '0 : remaining_reg - tlpd_pkg::LEN_W'(1);
                    if (is_last) begin
                        phase_next = tlpd_pkg::PH_IDLE;
                    end
                end
                default: begin
                    // idle, and the unused phase code
                    phase_next = tlpd_pkg::PH_IDLE;
                    if (s_tdata == tlpd_pkg::TYPE_FILLER) begin
                        res_valid = 1'b0;
                    end else if (s_tdata <= tlpd_pkg::TYPE_CTRL_MAX) begin
                        res_valid          = 1'b1;
                        res.kind           = tlpd_pkg::KIND_CTRL;
                        res.packet_type    = s_tdata;
                        res.last_of_packet = 1'b1;
                    end else begin
                        held_type_next    = s_tdata;
                        seen_next         = '0;
                        length_shift_next = '0;
                        remaining_next    = '0;
                        phase_next        = tlpd_pkg::PH_LEN;
                    end
                end
            endcase
        end
    end

    // Fill the output slot when it is free, else hold
    assign out_valid_next = s_tready ? (accept && res_valid) : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= tlpd_pkg::PH_IDLE;
            held_type_reg    <= '0;
            seen_reg         <= '0;
            length_shift_reg <= '0;
            remaining_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            held_type_reg    <= held_type_next;
            seen_reg         <= seen_next;
            length_shift_reg <= length_shift_next;
            remaining_reg    <= remaining_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.payload_length, out_reg.data_byte};
    assign m_tuser  = {out_reg.packet_type, out_reg.kind};
    assign m_tlast  = out_reg.last_of_packet;

    // Checks
    a_data_has_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == tlpd_pkg::PH_DATA |-> remaining_reg != '0)
        else $error("payload phase with no bytes remaining");

    a_no_stray_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == tlpd_pkg::KIND_CTRL
                   || m_tuser[1:0] == tlpd_pkg::KIND_DATA
                   || m_tuser[1:0] == tlpd_pkg::KIND_EMPTY))
        else $error("result of unknown kind");

    a_ctrl_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != tlpd_pkg::KIND_DATA |-> m_tlast && m_tdata == '0)
        else $error("control or empty result carries data");

    a_ready_only_blocked_by_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

endmodule
